FILE: rtl/acss_pkg.sv
package acss_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int TIME_W       = 48;
  localparam int CODE_W       = 24;
  localparam int CNT_W        = 32;
  localparam int PER_W        = 16;

  localparam logic [3:0] NONE_CH = 4'd8;

  localparam logic [7:0] CMD_WREG_MUX  = 8'h51;
  localparam logic [7:0] CMD_WREG_CNT  = 8'h00;
  localparam logic [3:0] MUX_NEG_AINCOM = 4'h8;
  localparam logic [7:0] CMD_SYNC      = 8'hFC;
  localparam logic [7:0] CMD_WAKEUP    = 8'h00;
  localparam logic [7:0] CMD_RDATA     = 8'h01;

  localparam logic [1:0] DLY_NONE = 2'd0;
  localparam logic [1:0] DLY_T11  = 2'd1;
  localparam logic [1:0] DLY_T6   = 2'd2;

  localparam logic [1:0] XFER_NONE  = 2'd0;
  localparam logic [1:0] XFER_ONE   = 2'd1;
  localparam logic [1:0] XFER_THREE = 2'd3;

  localparam logic [0:0] REG_READY_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SPI  = 2'd1,
    MODE_DRDY = 2'd2,
    MODE_CFG  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETUP  = 3'd1,
    PH_CONV   = 3'd2,
    PH_RDSENT = 3'd3,
    PH_READ   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_START,
    OP_SPI,
    OP_SAMPLE,
    OP_DRDY,
    OP_CFG,
    OP_TMO,
    OP_FIN_ADD,
    OP_FIN_CMP,
    OP_FIN_WR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIME_W-1:0]  now_ms;
    logic [CODE_W-1:0]  rx_bytes;
    logic [CH_W-1:0]    cfg_channel;
    logic               cfg_enable;
    logic [PER_W-1:0]   cfg_period;
  } acss_in_t;

  typedef struct packed {
    logic                      cs_low;
    logic [1:0]                xfer_len;
    logic [CODE_W-1:0]         xfer_bytes;
    logic [1:0]                delay_code;
    logic                      sample_valid;
    logic                      timeout_flag;
    logic [CH_W-1:0]           event_channel;
    logic [TIME_W-1:0]         sample_time;
    logic signed [CODE_W-1:0]  sample_code;
    logic [CNT_W-1:0]          timeout_count;
    logic [2:0]                phase;
    logic [3:0]                active_channel;
  } acss_out_t;

  typedef struct packed {
    op_t op;
  } acss_cmd_t;

  typedef struct packed {
    mode_t  mode;
    phase_t phase;
    logic   tmo_hit;
    logic   scan_last;
    logic   out_busy;
  } acss_stat_t;

endpackage

FILE: rtl/acss_ctrl.sv
module acss_ctrl
  import acss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  acss_stat_t stat,
  output acss_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_FIN_ADD,
    S_FIN_CMP,
    S_FIN_WR,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_TICK: begin
            if (stat.phase == PH_IDLE) begin
              state_nxt = S_SCAN;
            end else if (stat.tmo_hit) begin
              cmd.op    = OP_TMO;
              state_nxt = S_FIN_ADD;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          MODE_SPI: begin
            if (stat.phase == PH_READ) begin
              cmd.op    = OP_SAMPLE;
              state_nxt = S_FIN_ADD;
            end else begin
              cmd.op    = OP_SPI;
              state_nxt = S_EMIT;
            end
          end
          MODE_DRDY: begin
            cmd.op    = OP_DRDY;
            state_nxt = S_EMIT;
          end
          MODE_CFG: begin
            cmd.op    = OP_CFG;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.op    = OP_START;
        state_nxt = S_EMIT;
      end
      S_FIN_ADD: begin
        cmd.op    = OP_FIN_ADD;
        state_nxt = S_FIN_CMP;
      end
      S_FIN_CMP: begin
        cmd.op    = OP_FIN_CMP;
        state_nxt = S_FIN_WR;
      end
      S_FIN_WR: begin
        cmd.op    = OP_FIN_WR;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

FILE: rtl/acss_dp.sv
module acss_dp
  import acss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  acss_in_t         in_data,
  input  logic [CNT_W-1:0] ready_timeout_ms,
  input  acss_cmd_t        cmd,
  output acss_stat_t       stat,
  output acss_out_t        out_data,
  output logic             out_valid,
  input  logic             out_ready
);

  acss_in_t          in_r, in_nxt;
  phase_t            phase_r, phase_nxt;
  logic [3:0]        cur_r, cur_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [CH_W-1:0]   sel_r, sel_nxt;
  logic [CH_W-1:0]   best_r, best_nxt;
  logic [TIME_W-1:0] best_due_r, best_due_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [TIME_W-1:0] nd_r, nd_nxt;
  acss_out_t         res_r, res_nxt;
  acss_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              en_r   [NUM_CHANNELS];
  logic              en_nxt [NUM_CHANNELS];
  logic [PER_W-1:0]  per_r  [NUM_CHANNELS];
  logic [PER_W-1:0]  per_nxt[NUM_CHANNELS];
  logic [TIME_W-1:0] due_r  [NUM_CHANNELS];
  logic [TIME_W-1:0] due_nxt[NUM_CHANNELS];
  logic [CNT_W-1:0]  tmo_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]  tmo_nxt[NUM_CHANNELS];

  logic              sel_ok;
  logic              ent_en;
  logic [PER_W-1:0]  ent_per;
  logic [TIME_W-1:0] ent_due;
  logic [CNT_W-1:0]  ent_tmo;
  logic [TIME_W-1:0] age;
  logic              want_en;
  logic              cfg_change;
  logic              cur_ok;

  function automatic logic [27:0] setup_xfer(input logic [1:0] step, input logic [CH_W-1:0] ch);
    logic [27:0] x;
    if (step == 2'd0) begin
      x = {XFER_THREE, CMD_WREG_MUX, CMD_WREG_CNT, 1'b0, ch, MUX_NEG_AINCOM, DLY_NONE};
    end else if (step == 2'd1) begin
      x = {XFER_ONE, CMD_SYNC, 16'h0000, DLY_NONE};
    end else begin
      x = {XFER_ONE, CMD_WAKEUP, 16'h0000, DLY_T11};
    end
    return x;
  endfunction

  // All channel table reads go through the single select register.
  assign sel_ok  = ({1'b0, sel_r} < 4'(NUM_CHANNELS));
  assign ent_en  = sel_ok ? en_r[sel_r] : 1'b0;
  assign ent_per = sel_ok ? per_r[sel_r] : '0;
  assign ent_due = sel_ok ? due_r[sel_r] : '0;
  assign ent_tmo = sel_ok ? tmo_r[sel_r] : '0;

  assign age        = in_r.now_ms - stamp_r;
  assign want_en    = in_r.cfg_enable && (in_r.cfg_period != '0);
  assign cfg_change = (ent_en != want_en) || (ent_per != in_r.cfg_period);
  assign cur_ok     = (cur_r != NONE_CH);

  always_comb begin
    in_nxt        = in_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    stamp_nxt     = stamp_r;
    sel_nxt       = sel_r;
    best_nxt      = best_r;
    best_due_nxt  = best_due_r;
    best_vld_nxt  = best_vld_r;
    nd_nxt        = nd_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    en_nxt        = en_r;
    per_nxt       = per_r;
    due_nxt       = due_r;
    tmo_nxt       = tmo_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        in_nxt       = in_data;
        res_nxt      = '0;
        best_vld_nxt = 1'b0;
        if (in_data.mode == MODE_CFG) begin
          sel_nxt = in_data.cfg_channel;
        end else if (phase_r == PH_IDLE) begin
          sel_nxt = '0;
        end else begin
          sel_nxt = cur_r[CH_W-1:0];
        end
      end
      OP_SCAN: begin
        if (ent_en && (in_r.now_ms >= ent_due) && (!best_vld_r || (ent_due < best_due_r))) begin
          best_nxt     = sel_r;
          best_due_nxt = ent_due;
          best_vld_nxt = 1'b1;
        end
        sel_nxt = CH_W'(sel_r + 1'b1);
      end
      OP_START: begin
        if (best_vld_r) begin
          phase_nxt = PH_SETUP;
          cur_nxt   = {1'b0, best_r};
          step_nxt  = 2'd0;
          stamp_nxt = in_r.now_ms;
          {res_nxt.xfer_len, res_nxt.xfer_bytes, res_nxt.delay_code} = setup_xfer(2'd0, best_r);
        end
      end
      OP_SPI: begin
        if (phase_r == PH_SETUP) begin
          if (step_r < 2'd2) begin
            step_nxt = 2'(step_r + 1'b1);
            {res_nxt.xfer_len, res_nxt.xfer_bytes, res_nxt.delay_code} =
              setup_xfer(2'(step_r + 1'b1), cur_r[CH_W-1:0]);
          end else begin
            phase_nxt = PH_CONV;
            stamp_nxt = in_r.now_ms;
          end
        end else if (phase_r == PH_RDSENT) begin
          phase_nxt          = PH_READ;
          res_nxt.xfer_len   = XFER_THREE;
          res_nxt.xfer_bytes = '0;
          res_nxt.delay_code = DLY_T6;
        end
      end
      OP_SAMPLE: begin
        if (cur_ok) begin
          res_nxt.sample_valid  = 1'b1;
          res_nxt.event_channel = cur_r[CH_W-1:0];
          res_nxt.sample_time   = stamp_r;
          res_nxt.sample_code   = $signed(in_r.rx_bytes);
          res_nxt.timeout_count = ent_tmo;
        end
      end
      OP_DRDY: begin
        if (phase_r == PH_CONV) begin
          phase_nxt          = PH_RDSENT;
          stamp_nxt          = in_r.now_ms;
          res_nxt.xfer_len   = XFER_ONE;
          res_nxt.xfer_bytes = {CMD_RDATA, 16'h0000};
          res_nxt.delay_code = DLY_NONE;
        end
      end
      OP_CFG: begin
        if (sel_ok && cfg_change) begin
          en_nxt[sel_r]  = want_en;
          per_nxt[sel_r] = in_r.cfg_period;
          due_nxt[sel_r] = in_r.now_ms + TIME_W'(in_r.cfg_period);
        end
      end
      OP_TMO: begin
        if (cur_ok) begin
          tmo_nxt[sel_r]        = CNT_W'(ent_tmo + 1'b1);
          res_nxt.timeout_flag  = 1'b1;
          res_nxt.event_channel = cur_r[CH_W-1:0];
          res_nxt.timeout_count = CNT_W'(ent_tmo + 1'b1);
        end
      end
      OP_FIN_ADD: begin
        nd_nxt = ent_due + TIME_W'(ent_per);
      end
      OP_FIN_CMP: begin
        if (nd_r <= in_r.now_ms) begin
          nd_nxt = in_r.now_ms + TIME_W'(ent_per);
        end
      end
      OP_FIN_WR: begin
        if (cur_ok) begin
          due_nxt[sel_r] = nd_r;
        end
        phase_nxt = PH_IDLE;
        cur_nxt   = NONE_CH;
        step_nxt  = 2'd0;
      end
      OP_EMIT: begin
        out_nxt                = res_r;
        out_nxt.cs_low         = (phase_r != PH_IDLE);
        out_nxt.phase          = phase_r;
        out_nxt.active_channel = cur_r;
        out_valid_nxt          = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_r       <= NONE_CH;
      step_r      <= 2'd0;
      stamp_r     <= '0;
      sel_r       <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        en_r[i]  <= 1'b0;
        per_r[i] <= '0;
        due_r[i] <= '0;
        tmo_r[i] <= '0;
      end
    end else begin
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      step_r      <= step_nxt;
      stamp_r     <= stamp_nxt;
      sel_r       <= sel_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
      en_r        <= en_nxt;
      per_r       <= per_nxt;
      due_r       <= due_nxt;
      tmo_r       <= tmo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    best_r     <= best_nxt;
    best_due_r <= best_due_nxt;
    nd_r       <= nd_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign stat.mode      = in_r.mode;
  assign stat.phase     = phase_r;
  assign stat.tmo_hit   = (ready_timeout_ms != '0) && (in_r.now_ms >= stamp_r) &&
                          (age > TIME_W'(ready_timeout_ms));
  assign stat.scan_last = (sel_r == CH_W'(NUM_CHANNELS - 1));
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (cur_r == NONE_CH))
    else $error("phase and active channel disagree");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid_r || out_ready))
    else $error("result written over a beat that was not taken");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.sample_valid && out_r.timeout_flag))
    else $error("sample and timeout reported in one beat");

  a_cs_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.cs_low == (out_r.phase != 3'(PH_IDLE))))
    else $error("chip select does not follow phase");

endmodule

FILE: rtl/adc_channel_scan_sequencer.sv
// Scan sequencer for a multi-channel delta-sigma converter.
// The input channel (in_valid, in_ready, in_data) carries one event per beat:
// a tick, an SPI completion, a data-ready or a channel configure, each with
// a millisecond timestamp. Every accepted beat produces exactly one result
// beat on the output channel (out_valid, out_ready, out_data) that gives the
// SPI transfer to start, any finished sample or timeout, and the new phase.
// A tick while idle scans the channel table one entry per cycle and then
// starts the enabled, due channel with the earliest due time (the lower
// channel on a tie); a timeout or a finished sample goes through the FIN_ADD,
// FIN_CMP and FIN_WR steps, which set the channel's next due time.
// One event is handled at a time; the next beat is accepted in the cycle after
// the previous result reaches the output register.
// The APB port holds the data-ready timeout in milliseconds at address 0.
// Reset is synchronous and clears all channels to disabled with zero
// period, due time and timeout count, and returns the sequencer to idle.
// When the receiver stalls, the result is held and one more event may be
// taken and processed; its result then waits until the output frees.
module adc_channel_scan_sequencer
  import acss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  acss_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output acss_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CNT_W-1:0] timeout_r;
  logic [CNT_W-1:0] timeout_nxt;
  acss_cmd_t        cmd;
  acss_stat_t       stat;

  assign cfg_pready = 1'b1;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_READY_TIMEOUT)) begin
      timeout_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_READY_TIMEOUT) ? timeout_r : '0;

  acss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .ready_timeout_ms (timeout_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_data         (out_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

endmodule
